@@ hw/rtl/vector_table_linear_interpolator_core_macros.svh @@
// ----------------------------------------------------------------------------
// vector table interpolator assertion macros
// concurrent checks that compile away in synthesis
// ----------------------------------------------------------------------------
`ifndef VECTOR_TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define VECTOR_TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VTLI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define VTLI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define VTLI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VTLI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/vtli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtli_pkg
// shared types and constants of the vector table interpolator
// ----------------------------------------------------------------------------
package vtli_pkg;

  localparam int unsigned POS_W       = 32;
  localparam int unsigned COMP_W      = 32;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned WEIGHT_BITS = 24;
  localparam int unsigned NODE_MIN    = 2;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd2;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK             = 2'd0,
    STATUS_OUTSIDE        = 2'd1,
    STATUS_NOT_INCREASING = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                     kind;
    logic [SLOT_W-1:0]         node_index;
    logic [POS_W-1:0]          position;
    logic signed [COMP_W-1:0]  node_x;
    logic signed [COMP_W-1:0]  node_y;
    logic signed [COMP_W-1:0]  node_z;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [COMP_W-1:0]  result_x;
    logic signed [COMP_W-1:0]  result_y;
    logic signed [COMP_W-1:0]  result_z;
  } out_item_t;

  typedef struct packed {
    logic signed [COMP_W-1:0]  x;
    logic signed [COMP_W-1:0]  y;
    logic signed [COMP_W-1:0]  z;
  } vec3_t;

  // request after classification in the front end
  typedef struct packed {
    in_item_t item;
    logic     slot_ok;    // load slot lies inside the table
    logic     slot_zero;  // load to the first slot, never checked
  } cmd_t;

endpackage

@@ hw/rtl/vtli_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtli_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module vtli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/vtli_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtli_front
// accepts requests, classifies loads and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module vtli_front #(
  parameter int unsigned NODES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  vtli_pkg::in_item_t in_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output vtli_pkg::cmd_t     cmd_o
);

  vtli_pkg::cmd_t entry_q [2];
  vtli_pkg::cmd_t cmd_in;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;
  logic [31:0]    slot32;

  assign slot32            = 32'(in_i.node_index);
  assign cmd_in.item       = in_i;
  assign cmd_in.slot_ok    = (slot32 < NODES);
  assign cmd_in.slot_zero  = (in_i.node_index == '0);

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

@@ hw/rtl/vtli_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtli_back
// executes loads and queries against the node tables, holds the result
// ----------------------------------------------------------------------------
module vtli_back #(
  parameter int unsigned NODES = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  vtli_pkg::cmd_t           cmd_i,
  input  logic [$clog2(NODES)-1:0] last_idx_i,
  input  logic                     pop,
  output logic                     empty,
  output vtli_pkg::out_item_t      out_o
);

  localparam int unsigned AW   = $clog2(NODES);
  localparam int unsigned PW   = vtli_pkg::POS_W;
  localparam int unsigned CW   = vtli_pkg::COMP_W;
  localparam int unsigned WB   = vtli_pkg::WEIGHT_BITS;
  localparam int unsigned VW   = 3 * CW;
  localparam int unsigned PRW  = WB + 1 + CW + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_CHK, ST_SCAN, ST_SCAN_END, ST_DECIDE, ST_DIV,
    ST_RD_LO, ST_RD_HI, ST_MUL, ST_ADD, ST_MATCH_CAP, ST_OUT
  } state_e;

  typedef logic signed [PRW-1:0] prod_t;

  state_e                 state_q, state_d;
  vtli_pkg::cmd_t         cmd_q, cmd_d;
  logic [AW-1:0]          idx_q, idx_d, chk_idx_q, chk_idx_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [PW-1:0]          p0_q, p0_d, plast_q, plast_d, prev_q, prev_d;
  logic [PW-1:0]          lo_pos_q, lo_pos_d, hi_pos_q, hi_pos_d, span_q, span_d;
  logic [AW-1:0]          up_idx_q, up_idx_d, match_idx_q, match_idx_d;
  logic                   up_set_q, up_set_d, match_q, match_d;
  logic [PW-1:0]          rem_q, rem_d;
  logic [WB-1:0]          wgt_q, wgt_d;
  logic [4:0]             bit_cnt_q, bit_cnt_d;
  vtli_pkg::vec3_t        a_q, a_d;
  prod_t                  prod_x_q, prod_y_q, prod_z_q, prod_x_d, prod_y_d, prod_z_d;
  vtli_pkg::out_item_t    res_q, res_d, out_q, out_d;
  logic                   out_vld_q, out_vld_d;

  // ram ports
  logic                   wr_en;
  logic [AW-1:0]          wr_addr, pos_raddr, vec_raddr;
  logic [PW-1:0]          pos_rdata;
  logic [VW-1:0]          vec_rdata;
  vtli_pkg::vec3_t        wr_vec, rd_vec;

  logic [PW:0]            div_t;
  logic                   div_ge;
  logic signed [CW:0]     dx, dy, dz;
  logic signed [WB:0]     wgt_s;

  assign wr_vec.x = cmd_q.item.node_x;
  assign wr_vec.y = cmd_q.item.node_y;
  assign wr_vec.z = cmd_q.item.node_z;
  assign rd_vec   = vtli_pkg::vec3_t'(vec_rdata);
  assign wr_addr  = AW'(32'(cmd_q.item.node_index));

  vtli_ram #(.WIDTH(PW), .DEPTH(NODES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (cmd_q.item.position),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  vtli_ram #(.WIDTH(VW), .DEPTH(NODES)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (VW'(wr_vec)),
    .raddr_i (vec_raddr),
    .rdata_o (vec_rdata)
  );

  // one restoring division step
  assign div_t  = {rem_q, 1'b0};
  assign div_ge = (div_t >= {1'b0, span_q});

  assign wgt_s = $signed({1'b0, wgt_q});
  assign dx    = $signed({rd_vec.x[CW-1], rd_vec.x}) - $signed({a_q.x[CW-1], a_q.x});
  assign dy    = $signed({rd_vec.y[CW-1], rd_vec.y}) - $signed({a_q.y[CW-1], a_q.y});
  assign dz    = $signed({rd_vec.z[CW-1], rd_vec.z}) - $signed({a_q.z[CW-1], a_q.z});

  function automatic logic signed [CW-1:0] blend_add(logic signed [CW-1:0] a, prod_t p);
    prod_t sh;
    prod_t sum;
    sh  = p >>> WB;
    sum = PRW'(a) + sh;
    return sum[CW-1:0];
  endfunction

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    chk_idx_d   = chk_idx_q;
    chk_vld_d   = 1'b0;
    p0_d        = p0_q;
    plast_d     = plast_q;
    prev_d      = prev_q;
    lo_pos_d    = lo_pos_q;
    hi_pos_d    = hi_pos_q;
    span_d      = span_q;
    up_idx_d    = up_idx_q;
    up_set_d    = up_set_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    rem_d       = rem_q;
    wgt_d       = wgt_q;
    bit_cnt_d   = bit_cnt_q;
    a_d         = a_q;
    prod_x_d    = prod_x_q;
    prod_y_d    = prod_y_q;
    prod_z_d    = prod_z_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && !pop;
    cmd_ready_o = 1'b0;
    wr_en       = 1'b0;
    pos_raddr   = idx_q;
    vec_raddr   = match_idx_q;

    // scan compare of the entry read in the previous cycle
    if ((state_q == ST_SCAN || state_q == ST_SCAN_END) && chk_vld_q) begin
      if (chk_idx_q == '0) begin
        p0_d = pos_rdata;
      end
      if (chk_idx_q == last_idx_i) begin
        plast_d = pos_rdata;
      end
      if (pos_rdata == cmd_q.item.position && !match_q) begin
        match_d     = 1'b1;
        match_idx_d = chk_idx_q;
      end
      if (chk_idx_q != '0 && !up_set_q &&
          (pos_rdata > cmd_q.item.position || chk_idx_q == last_idx_i)) begin
        up_set_d = 1'b1;
        up_idx_d = chk_idx_q;
        hi_pos_d = pos_rdata;
        lo_pos_d = prev_q;
      end
      prev_d = pos_rdata;
    end

    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d              = cmd_i;
          res_d.status       = vtli_pkg::STATUS_OK;
          res_d.result_x     = '0;
          res_d.result_y     = '0;
          res_d.result_z     = '0;
          pos_raddr          = AW'(32'(cmd_i.item.node_index) - 32'd1);
          if (cmd_i.item.kind == vtli_pkg::KIND_QUERY) begin
            idx_d    = '0;
            up_set_d = 1'b0;
            match_d  = 1'b0;
            state_d  = ST_SCAN;
          end else if (!cmd_i.slot_ok) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_LD_CHK;
          end
        end
      end
      ST_LD_CHK: begin
        if (!cmd_q.slot_zero && cmd_q.item.position <= pos_rdata) begin
          res_d.status = vtli_pkg::STATUS_NOT_INCREASING;
        end else begin
          wr_en = 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_SCAN: begin
        chk_vld_d = 1'b1;
        chk_idx_d = idx_q;
        if (idx_q == last_idx_i) begin
          state_d = ST_SCAN_END;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_SCAN_END: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        rem_d     = cmd_q.item.position - lo_pos_q;
        span_d    = hi_pos_q - lo_pos_q;
        bit_cnt_d = '0;
        if (cmd_q.item.position < p0_q || cmd_q.item.position > plast_q) begin
          res_d.status = vtli_pkg::STATUS_OUTSIDE;
          state_d      = ST_OUT;
        end else if (match_q) begin
          vec_raddr = match_idx_q;
          state_d   = ST_MATCH_CAP;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d     = div_ge ? PW'(div_t - {1'b0, span_q}) : div_t[PW-1:0];
        wgt_d     = {wgt_q[WB-2:0], div_ge};
        bit_cnt_d = bit_cnt_q + 5'd1;
        if (bit_cnt_q == 5'(WB - 1)) begin
          state_d = ST_RD_LO;
        end
      end
      ST_RD_LO: begin
        vec_raddr = up_idx_q - AW'(1);
        state_d   = ST_RD_HI;
      end
      ST_RD_HI: begin
        a_d       = rd_vec;
        vec_raddr = up_idx_q;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        prod_x_d = PRW'(wgt_s * dx);
        prod_y_d = PRW'(wgt_s * dy);
        prod_z_d = PRW'(wgt_s * dz);
        state_d  = ST_ADD;
      end
      ST_ADD: begin
        res_d.result_x = blend_add(a_q.x, prod_x_q);
        res_d.result_y = blend_add(a_q.y, prod_y_q);
        res_d.result_z = blend_add(a_q.z, prod_z_q);
        state_d        = ST_OUT;
      end
      ST_MATCH_CAP: begin
        res_d.result_x = rd_vec.x;
        res_d.result_y = rd_vec.y;
        res_d.result_z = rd_vec.z;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (!out_vld_q || pop) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    idx_q       <= idx_d;
    chk_idx_q   <= chk_idx_d;
    p0_q        <= p0_d;
    plast_q     <= plast_d;
    prev_q      <= prev_d;
    lo_pos_q    <= lo_pos_d;
    hi_pos_q    <= hi_pos_d;
    span_q      <= span_d;
    up_idx_q    <= up_idx_d;
    up_set_q    <= up_set_d;
    match_q     <= match_d;
    match_idx_q <= match_idx_d;
    rem_q       <= rem_d;
    wgt_q       <= wgt_d;
    bit_cnt_q   <= bit_cnt_d;
    a_q         <= a_d;
    prod_x_q    <= prod_x_d;
    prod_y_q    <= prod_y_d;
    prod_z_q    <= prod_z_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign empty = !out_vld_q;
  assign out_o = out_q;

endmodule

@@ hw/rtl/vector_table_linear_interpolator_core.sv @@
// a load reads the position of the slot below and checks it before writing; a query scans the
//   nodes in use, then flags, takes the matching node, or divides, reads both nodes and blends
// throughput: one request at a time, set by the linear scan of the position ram
//   (one entry a cycle) and the weight divider; a load needs one ram read
// reset (rst_ni low, asynchronous) empties both queues and sets node_count to 2;
//   node tables are not cleared, no clearing pass
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_table_linear_interpolator_core
// piecewise linear interpolation over a table of three-component vectors
// ----------------------------------------------------------------------------
`include "vector_table_linear_interpolator_core_macros.svh"
module vector_table_linear_interpolator_core #(
  parameter int unsigned NODES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request side
  input  logic                        push,
  output logic                        full,
  input  vtli_pkg::in_item_t          in_i,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output vtli_pkg::out_item_t         out_o,
  // node_count register write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [vtli_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(NODES);

  logic [vtli_pkg::CFG_W-1:0] node_count_q;
  logic [31:0]                cnt32, n_use;
  logic [AW-1:0]              last_idx;
  logic                       cmd_valid, cmd_ready;
  vtli_pkg::cmd_t             cmd;

  // config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= vtli_pkg::NODE_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_count_q <= cfg_data_i;
    end
  end

  // clamp nodes in use to [2, NODES], pass on the last index in use
  assign cnt32 = 32'(node_count_q);
  always_comb begin
    if (cnt32 < vtli_pkg::NODE_MIN) begin
      n_use = vtli_pkg::NODE_MIN;
    end else if (cnt32 > NODES) begin
      n_use = NODES;
    end else begin
      n_use = cnt32;
    end
  end
  assign last_idx = AW'(n_use - 32'd1);

  // front: accept and classify requests
  // a two-entry request queue keeps accepting while a result waits to be popped
  vtli_front #(.NODES(NODES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back: scan, divide, blend and hold the result
  vtli_back #(.NODES(NODES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .last_idx_i  (last_idx),
    .pop         (pop),
    .empty       (empty),
    .out_o       (out_o)
  );

  // a flagged result never carries vector data
  `VTLI_ASSERT_IMP(a_flag_zero, clk_i, rst_ni, !empty && out_o.status != vtli_pkg::STATUS_OK, out_o.result_x == '0 && out_o.result_y == '0 && out_o.result_z == '0)
  // an accepted request always leaves the queue non-empty
  `VTLI_ASSERT_NXT(a_push_held, clk_i, rst_ni, push && !full, cmd_valid)
  // a config write lands in the register
  `VTLI_ASSERT_NXT(a_cfg_write, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, node_count_q == $past(cfg_data_i))

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector table interpolator testbench
// loads node tables, switches the node count between phases and fires
// queries under random push and pop stalls; every result is compared with
// an in-bench prediction of the table lookup and interpolation
// ----------------------------------------------------------------------------
module testbench;
  import vtli_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned ITEM_GOAL   = 950;

  // expected-result store plus a private copy of the node table
  class lookup_scoreboard;
    logic [POS_W-1:0]         pos_tab [TABLE_DEPTH];
    logic signed [COMP_W-1:0] x_tab [TABLE_DEPTH];
    logic signed [COMP_W-1:0] y_tab [TABLE_DEPTH];
    logic signed [COMP_W-1:0] z_tab [TABLE_DEPTH];
    bit                       written [TABLE_DEPTH];
    logic [CFG_W-1:0]         node_count;
    out_item_t                expected_q [$];
    int unsigned errors, loads, queries, flagged, outside, interps, configs;

    function new();
      node_count = NODE_COUNT_RST;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        pos_tab[i] = '0;
        x_tab[i] = '0;
        y_tab[i] = '0;
        z_tab[i] = '0;
        written[i] = 0;
      end
    endfunction

    function int unsigned in_use();
      if (node_count < NODE_MIN) return NODE_MIN;
      if (node_count > TABLE_DEPTH) return TABLE_DEPTH;
      return 32'(node_count);
    endfunction

    // slots written without a hole from slot zero
    function int unsigned filled();
      int unsigned k;
      k = 0;
      while (k < TABLE_DEPTH && written[k]) k++;
      return k;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_count(logic [CFG_W-1:0] v);
      node_count = v;
      configs++;
    endfunction

    // lower component plus floored weighted difference
    function logic signed [COMP_W-1:0] blend(logic signed [COMP_W-1:0] a,
                                             logic signed [COMP_W-1:0] b,
                                             longint w);
      longint prod;
      longint sum;
      prod = w * (longint'(b) - longint'(a));
      sum = longint'(a) + (prod >>> WEIGHT_BITS);
      return sum[COMP_W-1:0];
    endfunction

    function void note_request(in_item_t it);
      out_item_t e;
      int unsigned n, up, slot;
      bit hit;
      logic [63:0] span, offset, w;
      e = '0;
      e.status = STATUS_OK;
      slot = 32'(it.node_index);
      if (it.kind == KIND_LOAD) begin
        loads++;
        if (slot != 0 && it.position <= pos_tab[slot-1]) begin
          e.status = STATUS_NOT_INCREASING;
          flagged++;
        end else begin
          pos_tab[slot] = it.position;
          x_tab[slot] = it.node_x;
          y_tab[slot] = it.node_y;
          z_tab[slot] = it.node_z;
          written[slot] = 1;
        end
      end else begin
        queries++;
        n = in_use();
        if (it.position < pos_tab[0] || it.position > pos_tab[n-1]) begin
          e.status = STATUS_OUTSIDE;
          outside++;
        end else begin
          hit = 0;
          for (int i = 0; i < n && !hit; i++) begin
            if (pos_tab[i] == it.position) begin
              e.result_x = x_tab[i];
              e.result_y = y_tab[i];
              e.result_z = z_tab[i];
              hit = 1;
            end
          end
          if (!hit) begin
            // lowest slot above the query is the upper node
            up = n - 1;
            for (int i = n - 1; i >= 1; i--)
              if (pos_tab[i] > it.position) up = i;
            span = 64'(pos_tab[up]) - 64'(pos_tab[up-1]);
            offset = 64'(it.position) - 64'(pos_tab[up-1]);
            w = (offset << WEIGHT_BITS) / span;
            e.result_x = blend(x_tab[up-1], x_tab[up], longint'(w));
            e.result_y = blend(y_tab[up-1], y_tab[up], longint'(w));
            e.result_z = blend(z_tab[up-1], z_tab[up], longint'(w));
            interps++;
          end
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.result_x !== e.result_x) begin
        $display("%0t: result_x expected %h actual %h", $time, e.result_x, got.result_x);
        errors++;
      end
      if (got.result_y !== e.result_y) begin
        $display("%0t: result_y expected %h actual %h", $time, e.result_y, got.result_y);
        errors++;
      end
      if (got.result_z !== e.result_z) begin
        $display("%0t: result_z expected %h actual %h", $time, e.result_z, got.result_z);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  in_item_t         in_i;
  logic             empty;
  logic             pop;
  out_item_t        out_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  lookup_scoreboard sb;
  int unsigned      sent;
  int unsigned      send_idle;  // percent of cycles the request side holds off
  int unsigned      recv_idle;  // percent of cycles the result side holds off
  int unsigned      stall_cycles;

  vector_table_linear_interpolator_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // result side: random pop
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // handshakes are sampled on the falling edge ahead of the edge that takes them
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(out_o);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_request(in_item_t it);
    // idle profile follows progress through the run
    if (sent < ITEM_GOAL / 3) begin
      send_idle = 6;
      recv_idle = 45;
    end else if (sent < 2 * ITEM_GOAL / 3) begin
      send_idle = 45;
      recv_idle = 6;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    forever begin
      @(negedge clk_i);
      if (!full) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    sb.note_request(it);
    sent++;
  endtask

  task automatic send_load(int unsigned slot, logic [POS_W-1:0] pos,
                           logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    in_item_t it;
    it.kind = KIND_LOAD;
    it.node_index = slot[SLOT_W-1:0];
    it.position = pos;
    it.node_x = vx;
    it.node_y = vy;
    it.node_z = vz;
    send_request(it);
  endtask

  // vector fields carry noise on a query, the block must ignore them
  task automatic send_query(logic [POS_W-1:0] pos, int unsigned slot);
    in_item_t it;
    it.kind = KIND_QUERY;
    it.node_index = slot[SLOT_W-1:0];
    it.position = pos;
    it.node_x = $urandom;
    it.node_y = $urandom;
    it.node_z = $urandom;
    send_request(it);
  endtask

  // register write only once the block has drained
  task automatic write_node_count(logic [CFG_W-1:0] v);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_count(v);
  endtask

  // fresh table from slot zero, with the odd out-of-order load thrown in
  task automatic build_table(int unsigned n);
    longint pos, prev, stepmax;
    pos = ($urandom_range(3) == 0) ? longint'($urandom >> 4) : $urandom_range(0, 4096);
    stepmax = longint'(1) << $urandom_range(1, 22);
    for (int unsigned k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(11) == 0) begin
        prev = sb.pos_tab[k-1];
        send_load(k, 32'(prev - ((prev > 100) ? $urandom_range(0, 100) : 0)),
                  $urandom, $urandom, $urandom);
      end
      if (k > 0) pos = pos + 1 + ($urandom % stepmax);
      if (pos > 64'hFFFF_FFFF) pos = 64'hFFFF_FFFF;
      if (k > 0 && pos <= sb.pos_tab[k-1]) pos = sb.pos_tab[k-1] + 1;
      send_load(k, pos[31:0], $urandom, $urandom, $urandom);
    end
  endtask

  // node count within the gap-free part of the table, extremes included
  task automatic pick_node_count();
    int unsigned f;
    f = sb.filled();
    case ($urandom_range(5))
      0: write_node_count(7'($urandom_range(0, 1)));
      1: write_node_count((f == TABLE_DEPTH) ? 7'd127 : 7'(f));
      2: write_node_count((f == TABLE_DEPTH) ? 7'($urandom_range(65, 126)) : 7'd2);
      default: write_node_count(7'($urandom_range(2, f)));
    endcase
  endtask

  task automatic run_queries(int unsigned count);
    int unsigned n, slot;
    longint lo, hi;
    for (int unsigned q = 0; q < count; q++) begin
      n = sb.in_use();
      lo = sb.pos_tab[0];
      hi = sb.pos_tab[n-1];
      case ($urandom_range(9))
        0, 1, 2: send_query(sb.pos_tab[$urandom_range(0, n-1)], $urandom);
        3, 4, 5: begin
          if (hi > lo) send_query(32'(lo + (longint'($urandom) % (hi - lo + 1))), $urandom);
          else send_query(lo[31:0], $urandom);
        end
        6: send_query((lo > 0) ? 32'(longint'($urandom) % lo) : 32'd0, $urandom);
        7: begin
          if (hi < 64'hFFFF_FFFF)
            send_query(32'(hi + 1 + (longint'($urandom) % (64'hFFFF_FFFF - hi))), $urandom);
          else send_query(32'hFFFF_FFFF, $urandom);
        end
        8: send_query($urandom, $urandom);
        default: begin
          // stray load into the filled part or the slot just above it, may flag or unsort the table
          slot = $urandom_range(0, sb.filled());
          if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
          send_load(slot, (slot > 0 && $urandom_range(1))
                    ? sb.pos_tab[slot-1] + $urandom_range(0, 3) : $urandom,
                    $urandom, $urandom, $urandom);
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    sent = 0;
    send_idle = 6;
    recv_idle = 45;
    stall_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-range nodes, extreme components, exact ends and mid interpolation
    send_load(0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_load(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_load(1, 32'h0000_0000, 32'h1, 32'h2, 32'h3);  // equal position, flagged
    send_load(0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_query(32'h0000_0000, 0);
    send_query(32'hFFFF_FFFF, 63);
    send_query(32'h8000_0000, 42);
    send_query(32'h0000_0001, 21);
    send_query(32'hFFFF_FFFE, 0);
    // first slot reload is never checked; queries outside on both sides
    send_load(0, 32'h0000_0100, 32'h0100_0000, 32'hFF00_0000, 32'h0);
    send_query(32'h0000_0010, 0);
    send_load(1, 32'h0000_1000, 32'h0300_0000, 32'h0100_0000, 32'h7FFF_FFFF);
    send_query(32'h0000_2000, 0);
    send_query(32'h0000_0800, 0);
    // load beyond the node count is stored but not yet in use
    send_load(2, 32'h0000_2000, 32'h8000_0000, 32'h0, 32'h1);
    send_query(32'h0000_1800, 0);
    write_node_count(7'd3);
    // unsorted table: slot one now above slot two
    send_load(1, 32'h0000_3000, 32'h0200_0000, 32'hFE00_0000, 32'h0);
    send_query(32'h0000_1000, 0);
    send_query(32'h0000_2000, 0);
    send_query(32'h0000_1800, 0);
    write_node_count(7'd0);

    // full table early so the top slots and the count extremes get used
    build_table(TABLE_DEPTH);
    write_node_count(7'd127);
    run_queries(20);
    write_node_count(7'd64);
    run_queries(10);
    while (sent < ITEM_GOAL) begin
      build_table(($urandom_range(7) == 0) ? TABLE_DEPTH : $urandom_range(2, 12));
      pick_node_count();
      run_queries($urandom_range(5, 25));
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d requests: %0d loads (%0d flagged), %0d queries", sent, sb.loads,
             sb.flagged, sb.queries);
    $display("%0d outside, %0d interpolated, %0d node count writes", sb.outside,
             sb.interps, sb.configs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
